### rtl/core/uotl_pkg.sv
// Shared types and codes for the UTC offset transition lookup.
package uotl_pkg;

    localparam int TIME_W     = 64;
    localparam int OFFSET_W   = 32;
    localparam int DESIG_W    = 8;
    localparam int TYPE_IDX_W = 8;

    typedef enum logic [1:0] {
        CMD_CLEAR     = 2'd0,
        CMD_ADD_TYPE  = 2'd1,
        CMD_ADD_TRANS = 2'd2,
        CMD_QUERY     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_TYPE = 2'd1,
        ST_FULL     = 2'd2,
        ST_NO_TYPES = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                        command;
        logic signed [TIME_W-1:0]    utc_seconds;
        logic signed [OFFSET_W-1:0]  offset_seconds;
        logic                        dst_flag_in;
        logic [DESIG_W-1:0]          designation_in;
        logic [TYPE_IDX_W-1:0]       type_index;
    } request_t;

    typedef struct packed {
        status_t                     status;
        logic signed [OFFSET_W-1:0]  offset_out;
        logic                        dst_flag_out;
        logic [DESIG_W-1:0]          designation_out;
    } result_t;

    // One entry of the local type table.
    typedef struct packed {
        logic signed [OFFSET_W-1:0]  offset;
        logic                        dst;
        logic [DESIG_W-1:0]          desig;
    } type_entry_t;

    // Search engine handshake.
    typedef struct packed {
        logic                        start;
        logic                        sorted;
        logic signed [TIME_W-1:0]    t;
    } srch_req_t;

    typedef struct packed {
        logic                        done;
        logic [TYPE_IDX_W-1:0]       found;
    } srch_rsp_t;

endpackage

### rtl/core/uotl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module uotl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/uotl_search.sv
// Search engine: finds the last transition at or before a UTC instant.
module uotl_search
    import uotl_pkg::*;
#(
    parameter int MAX_TYPES       = 16,
    parameter int MAX_TRANSITIONS = 256,
    localparam int TYPE_W = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1,
    localparam int IDX_W  = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1,
    localparam int CNT_W  = $clog2(MAX_TRANSITIONS + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  srch_req_t                req,
    input  logic [CNT_W-1:0]         count,
    output logic [IDX_W-1:0]         rd_addr,
    input  logic signed [TIME_W-1:0] rd_time,
    input  logic [TYPE_W-1:0]        rd_type,
    output srch_rsp_t                rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_FIRST,
        S_BIN,
        S_LIN
    } state_t;

    state_t                   state_reg, state_next;
    logic signed [TIME_W-1:0] t_reg, t_next;
    logic                     sorted_reg, sorted_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         ptr_reg, ptr_next;
    logic [TYPE_W-1:0]        lo_type_reg, lo_type_next;

    logic                     le;
    logic [CNT_W-1:0]         addr_cnt;
    logic [CNT_W:0]           mid_sum;

    assign le      = (rd_time <= t_reg);
    assign rd_addr = addr_cnt[IDX_W-1:0];

    always_comb
    begin
        state_next   = state_reg;
        t_next       = t_reg;
        sorted_next  = sorted_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        ptr_next     = ptr_reg;
        lo_type_next = lo_type_reg;
        addr_cnt     = ptr_reg;
        mid_sum      = '0;
        rsp          = '0;

        case (state_reg)
            S_IDLE:
            begin
                addr_cnt = '0;
                if (req.start)
                begin
                    t_next      = req.t;
                    sorted_next = req.sorted;
                    state_next  = S_FIRST;
                end
            end
            S_FIRST:
            begin
                lo_type_next = rd_type;
                if (!le)
                begin
                    rsp.done   = 1'b1;
                    state_next = S_IDLE;
                end
                else if (count == CNT_W'(1))
                begin
                    rsp.done   = 1'b1;
                    rsp.found  = TYPE_IDX_W'(rd_type);
                    state_next = S_IDLE;
                end
                else if (sorted_reg)
                begin
                    lo_next    = '0;
                    hi_next    = count;
                    ptr_next   = count >> 1;
                    addr_cnt   = count >> 1;
                    state_next = S_BIN;
                end
                else
                begin
                    ptr_next   = count - CNT_W'(1);
                    addr_cnt   = count - CNT_W'(1);
                    state_next = S_LIN;
                end
            end
            S_BIN:
            begin
                // ptr_reg holds the probed midpoint
                if (le)
                begin
                    lo_next      = ptr_reg;
                    lo_type_next = rd_type;
                end
                else
                begin
                    hi_next = ptr_reg;
                end
                if ((CNT_W + 1)'(hi_next) > (CNT_W + 1)'(lo_next) + (CNT_W + 1)'(1))
                begin
                    mid_sum  = (CNT_W + 1)'(lo_next) + (CNT_W + 1)'(hi_next);
                    ptr_next = mid_sum[CNT_W:1];
                    addr_cnt = mid_sum[CNT_W:1];
                end
                else
                begin
                    rsp.done   = 1'b1;
                    rsp.found  = TYPE_IDX_W'(lo_type_next);
                    state_next = S_IDLE;
                end
            end
            S_LIN:
            begin
                // downward scan, entry 0 is already known to qualify
                if (le)
                begin
                    rsp.done   = 1'b1;
                    rsp.found  = TYPE_IDX_W'(rd_type);
                    state_next = S_IDLE;
                end
                else if (ptr_reg == CNT_W'(1))
                begin
                    rsp.done   = 1'b1;
                    rsp.found  = TYPE_IDX_W'(lo_type_reg);
                    state_next = S_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg - CNT_W'(1);
                    addr_cnt = ptr_reg - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            t_reg       <= '0;
            sorted_reg  <= 1'b1;
            lo_reg      <= '0;
            hi_reg      <= '0;
            ptr_reg     <= '0;
            lo_type_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            t_reg       <= t_next;
            sorted_reg  <= sorted_next;
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            ptr_reg     <= ptr_next;
            lo_type_reg <= lo_type_next;
        end
    end

endmodule

### rtl/core/utc_offset_transition_lookup.sv
// Top level of the UTC offset transition lookup: command decode, tables, result.
//
// A command is a transfer taken when start is high and busy is low; each
// command produces exactly one result, shown on result for a single cycle
// with done high, and the receiver cannot stall it. For clear, append type
// and append transition the result appears in the cycle after the transfer
// and busy stays low, so these commands may be issued on every clock. A
// query with stored transitions raises busy and walks the transition RAM
// through its single read port, one read per cycle: a read of the first
// entry, then a binary search when the stored instants are in ascending
// order, then a read of the type table. If instants were ever appended out
// of order the query scans downward from the newest entry instead. A query
// with no local types answers at once with status 3. Both tables hold
// undefined data after reset; only the fill counts are cleared, so no
// clearing pass is needed.
module utc_offset_transition_lookup
    import uotl_pkg::*;
#(
    parameter int MAX_TYPES       = 16,
    parameter int MAX_TRANSITIONS = 256
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  request_t request,
    output logic     done,
    output result_t  result
);

    localparam int TYPE_W  = (MAX_TYPES > 1) ? $clog2(MAX_TYPES) : 1;
    localparam int TCNT_W  = $clog2(MAX_TYPES + 1);
    localparam int IDX_W   = (MAX_TRANSITIONS > 1) ? $clog2(MAX_TRANSITIONS) : 1;
    localparam int CNT_W   = $clog2(MAX_TRANSITIONS + 1);
    localparam int ENTRY_W = TIME_W + TYPE_W;
    localparam int CMP_W   = 16;

    typedef enum logic [1:0] {
        T_IDLE,
        T_SEARCH,
        T_TYPE
    } state_t;

    state_t                   state_reg, state_next;
    logic                     done_reg, done_next;
    result_t                  result_reg, result_next;
    logic [TCNT_W-1:0]        type_count_reg, type_count_next;
    logic [CNT_W-1:0]         trans_count_reg, trans_count_next;
    logic                     sorted_reg, sorted_next;
    logic signed [TIME_W-1:0] last_time_reg, last_time_next;

    logic                     accept;

    // type table RAM
    logic                     type_we;
    logic [TYPE_W-1:0]        type_raddr;
    type_entry_t              type_wdata;
    logic [$bits(type_entry_t)-1:0] type_rdata;
    type_entry_t              type_rd;

    // transition RAM: instant and type index side by side
    logic                     trans_we;
    logic [ENTRY_W-1:0]       trans_wdata;
    logic [IDX_W-1:0]         trans_raddr;
    logic [ENTRY_W-1:0]       trans_rdata;

    srch_req_t                srch_req;
    srch_rsp_t                srch_rsp;
    logic [TYPE_W-1:0]        found_idx;

    assign accept = start && !busy;
    assign busy   = (state_reg != T_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assign type_wdata.offset = request.offset_seconds;
    assign type_wdata.dst    = request.dst_flag_in;
    assign type_wdata.desig  = request.designation_in;
    assign type_rd           = type_rdata;

    assign trans_wdata = {request.utc_seconds, request.type_index[TYPE_W-1:0]};

    assign srch_req.start  = accept && (request.command == CMD_QUERY)
                             && (type_count_reg != '0) && (trans_count_reg != '0);
    assign srch_req.sorted = sorted_reg;
    assign srch_req.t      = request.utc_seconds;

    // A stored type index is always below the type count; guard it anyway.
    always_comb
    begin
        if (CMP_W'(srch_rsp.found) >= CMP_W'(type_count_reg))
        begin
            found_idx = '0;
        end
        else
        begin
            found_idx = srch_rsp.found[TYPE_W-1:0];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        done_next        = 1'b0;
        result_next      = result_reg;
        type_count_next  = type_count_reg;
        trans_count_next = trans_count_reg;
        sorted_next      = sorted_reg;
        last_time_next   = last_time_reg;
        type_we          = 1'b0;
        trans_we         = 1'b0;
        type_raddr       = '0;

        case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    result_next = '0;
                    case (request.command)
                        CMD_CLEAR:
                        begin
                            type_count_next  = '0;
                            trans_count_next = '0;
                            sorted_next      = 1'b1;
                            done_next        = 1'b1;
                        end
                        CMD_ADD_TYPE:
                        begin
                            done_next = 1'b1;
                            if (CMP_W'(type_count_reg) >= CMP_W'(MAX_TYPES))
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                type_we         = 1'b1;
                                type_count_next = type_count_reg + TCNT_W'(1);
                            end
                        end
                        CMD_ADD_TRANS:
                        begin
                            done_next = 1'b1;
                            if (CMP_W'(request.type_index) >= CMP_W'(type_count_reg))
                            begin
                                result_next.status = ST_BAD_TYPE;
                            end
                            else if (CMP_W'(trans_count_reg) >= CMP_W'(MAX_TRANSITIONS))
                            begin
                                result_next.status = ST_FULL;
                            end
                            else
                            begin
                                trans_we         = 1'b1;
                                trans_count_next = trans_count_reg + CNT_W'(1);
                                last_time_next   = request.utc_seconds;
                                // one descent makes binary search unsafe until clear
                                if ((trans_count_reg != '0)
                                    && (last_time_reg > request.utc_seconds))
                                begin
                                    sorted_next = 1'b0;
                                end
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (type_count_reg == '0)
                            begin
                                done_next          = 1'b1;
                                result_next.status = ST_NO_TYPES;
                            end
                            else if (trans_count_reg == '0)
                            begin
                                type_raddr = '0;
                                state_next = T_TYPE;
                            end
                            else
                            begin
                                state_next = T_SEARCH;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            T_SEARCH:
            begin
                if (srch_rsp.done)
                begin
                    type_raddr = found_idx;
                    state_next = T_TYPE;
                end
            end
            T_TYPE:
            begin
                done_next                   = 1'b1;
                result_next.status          = ST_OK;
                result_next.offset_out      = type_rd.offset;
                result_next.dst_flag_out    = type_rd.dst;
                result_next.designation_out = type_rd.desig;
                state_next                  = T_IDLE;
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= T_IDLE;
            done_reg        <= 1'b0;
            result_reg      <= '0;
            type_count_reg  <= '0;
            trans_count_reg <= '0;
            sorted_reg      <= 1'b1;
            last_time_reg   <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            done_reg        <= done_next;
            result_reg      <= result_next;
            type_count_reg  <= type_count_next;
            trans_count_reg <= trans_count_next;
            sorted_reg      <= sorted_next;
            last_time_reg   <= last_time_next;
        end
    end

    uotl_ram #(
        .WIDTH ($bits(type_entry_t)),
        .DEPTH (MAX_TYPES)
    ) u_type_ram (
        .clk   (clk),
        .we    (type_we),
        .waddr (type_count_reg[TYPE_W-1:0]),
        .wdata (type_wdata),
        .raddr (type_raddr),
        .rdata (type_rdata)
    );

    uotl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TRANSITIONS)
    ) u_trans_ram (
        .clk   (clk),
        .we    (trans_we),
        .waddr (trans_count_reg[IDX_W-1:0]),
        .wdata (trans_wdata),
        .raddr (trans_raddr),
        .rdata (trans_rdata)
    );

    uotl_search #(
        .MAX_TYPES       (MAX_TYPES),
        .MAX_TRANSITIONS (MAX_TRANSITIONS)
    ) u_search (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (srch_req),
        .count   (trans_count_reg),
        .rd_addr (trans_raddr),
        .rd_time (trans_rdata[ENTRY_W-1:TYPE_W]),
        .rd_type (trans_rdata[TYPE_W-1:0]),
        .rsp     (srch_rsp)
    );

`ifndef SYNTHESIS
    // table edits answer in the very next cycle
    a_edit_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.command != CMD_QUERY)) |=> done)
        else $error("edit command without result in next cycle");

    // no result while a query is still in flight
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobe while busy");

    // every non-ok result carries a zero payload
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != ST_OK)) |->
        ((result.offset_out == '0) && !result.dst_flag_out
         && (result.designation_out == '0)))
        else $error("failed command with nonzero payload");

    // fill counts stay within the tables
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (CMP_W'(type_count_reg) <= CMP_W'(MAX_TYPES))
        && (CMP_W'(trans_count_reg) <= CMP_W'(MAX_TRANSITIONS)))
        else $error("fill count beyond table depth");

    // search finishes only while a query is in flight
    a_search_owned: assert property (@(posedge clk) disable iff (!rst_n)
        srch_rsp.done |-> (state_reg == T_SEARCH))
        else $error("search completion outside a query");
`endif

endmodule
